// File: hdl/assert_macros.svh
// Assertion macros for the checker file of the header field splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define HFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define HFS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hfs_pkg.sv
// Shared types and constants of the header field splitter.
`timescale 1ns / 1ps

package hfs_pkg;

	// Default longest buffer before positions saturate.
	localparam int HFS_MAX_LEN = 4096;

	// Width of each reported position or length.
	localparam int FIELD_W = 13;

	// Entries in the queue between the classifier and the parser.
	localparam int QUEUE_DEPTH = 4;

	// Byte codes that the classifier looks for.
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Class of one byte, as handed from the classifier to the parser.
	typedef struct packed {
		logic colon;
		logic blank;
		logic ws;
		logic newline;
		logic last;
	} hfs_class_t;

	// One parse result.
	typedef struct packed {
		logic               too_long;
		logic [FIELD_W-1:0] body_length;
		logic [FIELD_W-1:0] body_offset;
		logic [FIELD_W-1:0] name_length;
	} hfs_result_t;

endpackage

// File: hdl/header_field_splitter.sv
// Top level of the header field splitter.
`timescale 1ns / 1ps

// Splits one header line, fed one byte per transfer with tlast on the final
// byte, into the name length, the body offset and the trimmed body length.
// A folded line (newline followed by a space or tab) continues the body.
// One result transfer follows each final byte. The block takes one byte per
// clock cycle while results are taken; the limit is the parser's position
// update. A result passes through the classifier register, the queue and the
// output register after its final byte is transferred in. While a result
// waits on m_tready, bytes that end no buffer keep flowing; the next final
// byte waits at the parser, and once the queue and the classifier register
// fill up, s_tready drops until the waiting result is transferred.
// Buffers longer than MAX_LEN bytes set too_long, with all positions
// saturated at MAX_LEN and then reported modulo 8192.
module header_field_splitter
	import hfs_pkg::*;
#(
	parameter int MAX_LEN = HFS_MAX_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [12:0] name_length, [25:13] body_offset,
	                               // [38:26] body_length, [39] zero
	output logic [0:0]  m_tuser    // [0] too_long
);

	logic        push_valid;
	logic        push_ready;
	hfs_class_t  push_data;
	logic        pop_valid;
	logic        pop_ready;
	hfs_class_t  pop_data;
	hfs_result_t res;

	hfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	hfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	hfs_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (res)
	);

	// Pack the result fields, lowest field first.
	assign m_tdata = {1'b0, res.body_length, res.body_offset, res.name_length};
	assign m_tuser = res.too_long;

endmodule

// File: hdl/hfs_front.sv
// Input stage: accepts bytes and classifies each one.
`timescale 1ns / 1ps

module hfs_front
	import hfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	output logic       push_valid,
	input  logic       push_ready,
	output hfs_class_t push_data
);

	logic       valid_s1;
	hfs_class_t cls_s1;
	hfs_class_t cls;

	// Compare the byte against the characters that steer the parser.
	always_comb begin
		cls.colon   = (s_tdata == CH_COLON);
		cls.blank   = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
		cls.newline = (s_tdata == CH_LF);
		cls.ws      = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB) ||
			(s_tdata == CH_LF) || (s_tdata == CH_VT) ||
			(s_tdata == CH_FF) || (s_tdata == CH_CR);
		cls.last    = s_tlast;
	end

	// The stage takes a new byte whenever its own slot is empty or empties this cycle.
	assign s_tready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cls_s1 <= cls;
		end
	end

endmodule

// File: hdl/hfs_queue.sv
// Short queue of classified bytes between the classifier and the parser.
`timescale 1ns / 1ps

module hfs_queue
	import hfs_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  hfs_class_t push_data,
	output logic       pop_valid,
	input  logic       pop_ready,
	output hfs_class_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	hfs_class_t       entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/hfs_back.sv
// Parser: tracks name and body positions and registers the result.
`timescale 1ns / 1ps

module hfs_back
	import hfs_pkg::*;
#(
	parameter int MAX_LEN = HFS_MAX_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  hfs_class_t  pop_data,
	output logic        res_valid,
	input  logic        res_ready,
	output hfs_result_t res_data
);

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

	typedef enum logic [3:0] {
		PH_NAME = 4'b0001,
		PH_SKIP = 4'b0010,
		PH_BODY = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] name_end_q, name_end_n;
	logic [POS_W-1:0] begin_q, begin_n;
	logic [POS_W-1:0] end_q, end_n;
	logic        pend_nl_q, pend_nl_n;
	logic        ovf_q, ovf_n;
	logic [POS_W:0]   pos_p1;
	logic [POS_W-1:0] pos_next;
	logic [POS_W-1:0] body_len;
	logic        take;
	logic        res_valid_q;
	hfs_result_t res_q;

	// A byte that ends no buffer can always be taken; a final byte needs the output slot.
	assign pop_ready = !pop_data.last || !res_valid_q || res_ready;
	assign take      = pop_valid && pop_ready;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Saturating increment of the byte index.
	assign pos_p1   = {1'b0, pos_q} + 1'b1;
	assign pos_next = (pos_p1 >= {1'b0, MAX_POS}) ? MAX_POS : pos_p1[POS_W-1:0];

	// Next state of the parser for the byte at the head of the queue.
	always_comb begin
		phase_n    = phase_q;
		name_end_n = name_end_q;
		begin_n    = begin_q;
		end_n      = end_q;
		pend_nl_n  = pend_nl_q;
		ovf_n      = ovf_q || (pos_q == MAX_POS);
		case (phase_q)
			PH_NAME: begin
				if (pop_data.colon) begin
					phase_n = PH_SKIP;
					begin_n = pos_next;
					end_n   = pos_next;
				end else begin
					if (!pop_data.ws) begin
						name_end_n = pos_next;
					end
					if (pop_data.last) begin
						begin_n = pos_next;
						end_n   = pos_next;
					end
				end
			end
			PH_SKIP: begin
				if (pop_data.blank) begin
					begin_n = pos_next;
					end_n   = pos_next;
				end else begin
					// First body byte; no newline can be pending yet.
					phase_n = PH_BODY;
					begin_n = pos_q;
					end_n   = pop_data.ws ? pos_q : pos_next;
					pend_nl_n = pop_data.newline;
				end
			end
			PH_BODY: begin
				if (pend_nl_q) begin
					// A blank after a newline folds the line; anything else ends the body.
					if (pop_data.blank) begin
						pend_nl_n = 1'b0;
					end else begin
						phase_n = PH_DONE;
					end
				end else begin
					if (pop_data.newline) begin
						pend_nl_n = 1'b1;
					end
					if (!pop_data.ws) begin
						end_n = pos_next;
					end
				end
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase
	end

	assign body_len = end_n - begin_n;

	// Parser state returns to its start after each final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_NAME;
			pos_q      <= '0;
			name_end_q <= '0;
			begin_q    <= '0;
			end_q      <= '0;
			pend_nl_q  <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (take) begin
			if (pop_data.last) begin
				phase_q    <= PH_NAME;
				pos_q      <= '0;
				name_end_q <= '0;
				begin_q    <= '0;
				end_q      <= '0;
				pend_nl_q  <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				pos_q      <= pos_next;
				name_end_q <= name_end_n;
				begin_q    <= begin_n;
				end_q      <= end_n;
				pend_nl_q  <= pend_nl_n;
				ovf_q      <= ovf_n;
			end
		end
	end

	// Output register holds the result until the downstream transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && pop_data.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pop_data.last) begin
			res_q.name_length <= FIELD_W'(name_end_n);
			res_q.body_offset <= FIELD_W'(begin_n);
			res_q.body_length <= FIELD_W'(body_len);
			res_q.too_long    <= ovf_n;
		end
	end

endmodule

// File: hdl/hfs_checker.sv
// Port-level checker for the header field splitter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hfs_checker #(
	parameter int MAX_LEN = 4096
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [0:0]  m_tuser
);

	localparam bit WRAPS = (MAX_LEN > 8191);

	// A stalled result stays offered and unchanged.
	`HFS_ASSERT(a_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`HFS_ASSERT(a_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// No result is offered while in reset.
	`HFS_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid, "result offered during reset")

	// The name ends at or before the body start.
	`HFS_ASSERT(a_name_before_body, m_tvalid |-> WRAPS || (m_tdata[12:0] <= m_tdata[25:13]), "name ends after body start")

	// The body never reaches past the saturated buffer length.
	`HFS_ASSERT(a_body_in_range, m_tvalid |-> WRAPS || ({1'b0, m_tdata[25:13]} + {1'b0, m_tdata[38:26]} <= 14'(MAX_LEN)), "body runs past buffer limit")

endmodule

bind header_field_splitter hfs_checker #(.MAX_LEN(MAX_LEN)) u_hfs_checker (.*);

// File: test/tb_header_field_splitter.sv
// Self-checking testbench for the header field splitter: byte streams in, split results checked.
`timescale 1ns / 1ps

module tb_header_field_splitter;
	import hfs_pkg::*;

	localparam int LINE_MAX    = HFS_MAX_LEN;
	localparam int HOLD_CYCLES = 300;

	// One expected split of a header line.
	typedef struct {
		logic [FIELD_W-1:0] name_len;
		logic [FIELD_W-1:0] body_off;
		logic [FIELD_W-1:0] body_len;
		logic               too_long;
	} split_t;

	// Tracks the parse of each accepted byte and checks every result transfer in order.
	class split_scoreboard;
		typedef enum logic [1:0] {SCAN_NAME, SCAN_BLANKS, SCAN_BODY, SCAN_DONE} scan_phase_t;

		int unsigned        limit_len;
		scan_phase_t        phase;
		logic [FIELD_W-1:0] pos;
		logic [FIELD_W-1:0] name_end;
		logic [FIELD_W-1:0] body_start;
		logic [FIELD_W-1:0] body_end;
		bit                 newline_held;
		bit                 overflowed;
		split_t             expected_q[$];
		int                 errors;
		int                 checked;
		int                 too_long_count;

		function new(int unsigned max_len);
			limit_len = max_len;
			errors = 0;
			checked = 0;
			too_long_count = 0;
			clear_state();
		endfunction

		function void clear_state();
			phase = SCAN_NAME;
			pos = '0;
			name_end = '0;
			body_start = '0;
			body_end = '0;
			newline_held = 0;
			overflowed = 0;
		endfunction

		function bit is_ws(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_LF ||
				c == CH_VT || c == CH_FF || c == CH_CR;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB;
		endfunction

		// Next byte index, held at the length limit.
		function logic [FIELD_W-1:0] step_pos(logic [FIELD_W-1:0] p);
			int unsigned nxt;
			nxt = 32'(p) + 1;
			return (nxt >= limit_len) ? FIELD_W'(limit_len) : FIELD_W'(nxt);
		endfunction

		// A newline followed by a blank folds the line; anything else ends the body.
		function void body_byte(logic [7:0] c, logic [FIELD_W-1:0] p);
			if (newline_held) begin
				if (is_blank(c))
					newline_held = 0;
				else
					phase = SCAN_DONE;
				return;
			end
			if (c == CH_LF)
				newline_held = 1;
			if (!is_ws(c))
				body_end = step_pos(p);
		endfunction

		function void note_byte(logic [7:0] c, bit last);
			logic [FIELD_W-1:0] p;
			split_t             want;
			if (pos >= limit_len) begin
				overflowed = 1;
				pos = FIELD_W'(limit_len);
			end
			p = pos;
			case (phase)
				SCAN_NAME: begin
					if (c == CH_COLON) begin
						phase = SCAN_BLANKS;
						body_start = step_pos(p);
						body_end = body_start;
					end else begin
						if (!is_ws(c))
							name_end = step_pos(p);
						if (last) begin
							body_start = step_pos(p);
							body_end = body_start;
						end
					end
				end
				SCAN_BLANKS: begin
					if (is_blank(c)) begin
						body_start = step_pos(p);
						body_end = body_start;
					end else begin
						phase = SCAN_BODY;
						body_start = p;
						body_end = p;
						body_byte(c, p);
					end
				end
				SCAN_BODY: body_byte(c, p);
				default: ;
			endcase
			pos = step_pos(p);
			if (last) begin
				want.name_len = name_end;
				want.body_off = body_start;
				want.body_len = body_end - body_start;
				want.too_long = overflowed;
				expected_q.push_back(want);
				clear_state();
			end
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH at %0t ns: %s", $time, msg);
		endtask

		task check_result(logic [39:0] data, logic [0:0] user);
			split_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result transfer with no buffer outstanding");
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (want.too_long)
				too_long_count++;
			if (data[FIELD_W-1:0] !== want.name_len)
				report_mismatch($sformatf("name_length got %0d want %0d",
					data[FIELD_W-1:0], want.name_len));
			if (data[2*FIELD_W-1:FIELD_W] !== want.body_off)
				report_mismatch($sformatf("body_offset got %0d want %0d",
					data[2*FIELD_W-1:FIELD_W], want.body_off));
			if (data[3*FIELD_W-1:2*FIELD_W] !== want.body_len)
				report_mismatch($sformatf("body_length got %0d want %0d",
					data[3*FIELD_W-1:2*FIELD_W], want.body_len));
			if (data[39] !== 1'b0)
				report_mismatch("tdata padding bit is not zero");
			if (user[0] !== want.too_long)
				report_mismatch($sformatf("too_long got %b want %b", user[0], want.too_long));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;

	split_scoreboard sb = new(LINE_MAX);

	logic [7:0] line_q[$];
	bit         send_gaps;
	bit         ready_gaps;
	bit         hold_req;
	int         chars_sent;
	int         lines_sent;
	int         input_stalls;

	header_field_splitter #(
		.MAX_LEN(LINE_MAX)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog for a hung run.
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Watch both sides and feed the scoreboard on every transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_byte(s_tdata, s_tlast);
			if (s_tvalid && !s_tready)
				input_stalls++;
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
		end
	end

	// Result side: random back-pressure, plus one long hold when asked for.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end else if (ready_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one byte, with an optional idle burst first, and wait for its transfer.
	task automatic send_char(input logic [7:0] c, input bit last);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_char(line_q[i], i == line_q.size() - 1);
		lines_sent++;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	task automatic send_text(string s);
		line_q.delete();
		push_text(s);
		send_line();
	endtask

	function automatic logic [7:0] any_non_colon();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_COLON);
		return c;
	endfunction

	// Mostly letters, digits and dashes; now and then any byte but a colon.
	function automatic logic [7:0] token_char();
		case ($urandom_range(0, 7))
			0: return any_non_colon();
			1: return 8'h30 + 8'($urandom_range(0, 9));
			2: return 8'h2D;
			3, 4: return 8'h61 + 8'($urandom_range(0, 25));
			default: return 8'h41 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic logic [7:0] ws_char();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] odd_char();
		case ($urandom_range(0, 3))
			0: return CH_COLON;
			1: return blank_char();
			default: return ws_char();
		endcase
	endfunction

	// Mostly well-formed header line with random content, folds and trailing junk.
	function automatic void build_header();
		int segs;
		line_q.delete();
		repeat ($urandom_range(1, 8)) line_q.push_back(token_char());
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) line_q.push_back(ws_char());
		if ($urandom_range(0, 9) == 0)
			return;
		line_q.push_back(CH_COLON);
		repeat ($urandom_range(0, 3)) line_q.push_back(blank_char());
		segs = $urandom_range(0, 3);
		for (int s = 0; s < segs; s++) begin
			repeat ($urandom_range(1, 5))
				line_q.push_back($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 255))
					: token_char());
			if (s < segs - 1) begin
				case ($urandom_range(0, 2))
					0: line_q.push_back(CH_SPACE);
					1: begin
						line_q.push_back(CH_CR);
						line_q.push_back(CH_LF);
						line_q.push_back(blank_char());
					end
					default: begin
						line_q.push_back(CH_LF);
						repeat ($urandom_range(1, 2)) line_q.push_back(blank_char());
					end
				endcase
			end
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) line_q.push_back(ws_char());
		if ($urandom_range(0, 1) == 0) begin
			line_q.push_back(CH_CR);
			line_q.push_back(CH_LF);
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Unstructured bytes, rich in colons, blanks and newlines.
	function automatic void build_noise(int max_len);
		line_q.delete();
		repeat ($urandom_range(1, max_len))
			line_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : odd_char());
	endfunction

	// Main stimulus.
	initial begin
		int rand_lines;
		int rand_start;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tlast    <= 1'b0;
		send_gaps  = 1;
		ready_gaps = 1;
		hold_req   = 0;
		chars_sent = 0;
		lines_sent = 0;
		input_stalls = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: single bytes, trimming, folding, no colon, blanks-only body.
		send_text("A");
		send_text(":");
		send_text("Subject: hello");
		send_text("Name \t: \t value \r\n");
		send_text("X: a\r\n b\r\nY: junk");
		send_text("abc  ");
		send_text("K: \t");
		send_text("  \t\r");
		send_text("A:b\nc");
		send_text("A:b\n");
		send_text("A:b\n\n x");
		send_text("A:b\n\tc\n d e \r\n");
		send_text("::");
		send_text("A: :b");
		line_q.delete();
		line_q.push_back(8'h00);
		line_q.push_back(CH_COLON);
		line_q.push_back(8'hFF);
		send_line();
		line_q.delete();
		line_q.push_back(8'h41);
		line_q.push_back(CH_VT);
		line_q.push_back(CH_COLON);
		line_q.push_back(CH_FF);
		line_q.push_back(8'h78);
		line_q.push_back(CH_CR);
		send_line();

		// Random lines, mostly well formed.
		rand_lines = 0;
		rand_start = chars_sent;
		while (chars_sent - rand_start < 160 || rand_lines < 12) begin
			if ($urandom_range(0, 3) == 0)
				build_noise(16);
			else
				build_header();
			send_line();
			rand_lines++;
		end

		// Short lines while the result side holds off, so the input backs up.
		hold_req = 1;
		repeat (40) begin
			build_noise(3);
			send_line();
		end

		// Closing stretch at full rate on both sides.
		send_gaps  = 0;
		ready_gaps = 0;
		repeat (6) begin
			build_header();
			send_line();
		end
		s_tvalid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d header lines (%0d bytes), checked %0d results, %0d over the length limit.",
			lines_sent, chars_sent, sb.checked, sb.too_long_count);
		$display("Input was held back for %0d cycles; %0d mismatches found.",
			input_stalls, sb.errors);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/hfs_pkg.sv
hdl/hfs_front.sv
hdl/hfs_queue.sv
hdl/hfs_back.sv
hdl/header_field_splitter.sv
hdl/hfs_checker.sv
test/tb_header_field_splitter.sv
